FILE: sv/ssf_pkg.sv
// Shared types, constants and helper functions of the shifted soft pair force block.
`timescale 1ns / 1ps

package ssf_pkg;

   localparam int FRAC_BITS_DEF   = 16;
   localparam int TRIG_STAGES_DEF = 16;
   localparam int QUEUE_DEPTH     = 4;

   localparam logic [31:0] PI_Q30      = 32'd3373259426;
   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [31:0] ONE_Q30     = 32'd1073741824;
   localparam logic [31:0] GAIN_Q30    = 32'h26DD3B6A;

   // arctan(2^-k) in Q2.30, truncated
   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   // sign-split data that rides along the whole pipeline
   typedef struct packed {
      logic [2:0]       dneg;
      logic [2:0][31:0] dmag;
      logic             aneg;
      logic [31:0]      m;
      logic             in_range;
   } pass_type;

   // queue entry between front and back
   typedef struct packed {
      pass_type    pass;
      logic [31:0] sh;
      logic [31:0] cut;
      logic [63:0] rsq;
   } work_type;

   typedef struct packed {
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic signed [31:0] fz;
      logic signed [31:0] force_scale;
      logic signed [31:0] energy;
      logic               in_range;
   } rsp_word_type;

   // magnitude of a 32 bit two's complement value (-2^31 gives 2^31)
   function automatic logic [31:0] abs32(logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
   endfunction

   // clamp a magnitude to the signed 32 bit range for the given sign
   function automatic logic [31:0] sat_mag(logic neg, logic [63:0] mag);
      logic [63:0] lim;
      lim = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
      return (mag > lim) ? lim[31:0] : mag[31:0];
   endfunction

   // saturate and apply sign
   function automatic logic [31:0] sat_field(logic neg, logic [63:0] mag);
      logic [31:0] mg;
      mg = sat_mag(neg, mag);
      return neg ? (32'd0 - mg) : mg;
   endfunction

endpackage

FILE: sv/ssf_req_if.sv
// Input channel: one pair word with valid/ready handshake.
`timescale 1ns / 1ps

interface ssf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] dx;
   logic signed [31:0] dy;
   logic signed [31:0] dz;
   logic [15:0]        weight;
   logic signed [31:0] strength;
   logic [31:0]        shift_dist;
   logic [31:0]        cutoff;

   modport source (output valid, dx, dy, dz, weight, strength, shift_dist, cutoff,
                   input ready);
   modport sink   (input valid, dx, dy, dz, weight, strength, shift_dist, cutoff,
                   output ready);
endinterface

FILE: sv/ssf_rsp_if.sv
// Result channel: one force/energy word with valid/ready handshake.
`timescale 1ns / 1ps

interface ssf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] fx;
   logic signed [31:0] fy;
   logic signed [31:0] fz;
   logic signed [31:0] force_scale;
   logic signed [31:0] energy;
   logic               in_range;

   modport source (output valid, fx, fy, fz, force_scale, energy, in_range, input ready);
   modport sink   (input valid, fx, fy, fz, force_scale, energy, in_range, output ready);
endinterface

FILE: sv/ssf_front.sv
// Front end: takes pair words, forms r^2, the cutoff test and the weighted strength.
`timescale 1ns / 1ps

module ssf_front import ssf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   ssf_req_if.sink  req_ch,
   output work_type push_data,
   output logic     push_valid,
   input  logic     push_ready
);

   typedef struct packed {
      logic [2:0]       dneg;
      logic [2:0][31:0] dmag;
      logic             aneg;
      logic [31:0]      sh;
      logic [31:0]      cut;
      logic [2:0][63:0] sq;
      logic [63:0]      cutsq;
      logic [47:0]      wa;
   } f1_type;

   typedef struct packed {
      logic [2:0]       dneg;
      logic [2:0][31:0] dmag;
      logic             aneg;
      logic [31:0]      sh;
      logic [31:0]      cut;
      logic [63:0]      rsq;
      logic [63:0]      cutsq;
      logic [31:0]      m;
   } f2_type;

   f1_type     f1_ff, f1_in;
   f2_type     f2_ff, f2_in;
   work_type   f3_ff, f3_in;
   logic [2:0] vld_ff;
   logic       en;

   assign en           = !vld_ff[2] || push_ready;
   assign req_ch.ready = en;
   assign push_valid   = vld_ff[2];
   assign push_data    = f3_ff;

   // stage 1: sign split and squares
   always_comb begin
      logic [31:0] amag;
      f1_in.dneg    = {req_ch.dz[31], req_ch.dy[31], req_ch.dx[31]};
      f1_in.dmag[0] = abs32(req_ch.dx);
      f1_in.dmag[1] = abs32(req_ch.dy);
      f1_in.dmag[2] = abs32(req_ch.dz);
      f1_in.aneg    = req_ch.strength[31];
      amag          = abs32(req_ch.strength);
      f1_in.sh      = req_ch.shift_dist;
      f1_in.cut     = req_ch.cutoff;
      for (int j = 0; j < 3; j++) begin
         f1_in.sq[j] = 64'(f1_in.dmag[j]) * 64'(f1_in.dmag[j]);
      end
      f1_in.cutsq = 64'(req_ch.cutoff) * 64'(req_ch.cutoff);
      f1_in.wa    = 48'(req_ch.weight) * 48'(amag);
   end

   // stage 2: sum of squares, strength rounded to the data format
   always_comb begin
      logic [47:0] wr;
      f2_in.dneg  = f1_ff.dneg;
      f2_in.dmag  = f1_ff.dmag;
      f2_in.aneg  = f1_ff.aneg;
      f2_in.sh    = f1_ff.sh;
      f2_in.cut   = f1_ff.cut;
      f2_in.rsq   = f1_ff.sq[0] + f1_ff.sq[1] + f1_ff.sq[2];
      f2_in.cutsq = f1_ff.cutsq;
      wr          = f1_ff.wa + 48'd16384;
      f2_in.m     = wr[46:15];
   end

   // stage 3: cutoff test
   always_comb begin
      f3_in.pass.dneg     = f2_ff.dneg;
      f3_in.pass.dmag     = f2_ff.dmag;
      f3_in.pass.aneg     = f2_ff.aneg;
      f3_in.pass.m        = f2_ff.m;
      f3_in.pass.in_range = f2_ff.rsq < f2_ff.cutsq;
      f3_in.sh            = f2_ff.sh;
      f3_in.cut           = f2_ff.cut;
      f3_in.rsq           = f2_ff.rsq;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_ff <= f1_in;
         f2_ff <= f2_in;
         f3_ff <= f3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], req_ch.valid};
      end
   end

endmodule

FILE: sv/ssf_queue.sv
// Short queue between front end and back end.
`timescale 1ns / 1ps

module ssf_queue import ssf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  work_type push_data,
   input  logic     push_valid,
   output logic     push_ready,
   output work_type head,
   output logic     head_valid,
   input  logic     pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign push_ready = cnt_ff != CNT_W'(QUEUE_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head       = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   // pointer and fill bookkeeping
   always_comb begin
      wr_in  = do_push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/ssf_back.sv
// Back end: square root, phase divide, CORDIC, energy and force scale, force words.
`timescale 1ns / 1ps

module ssf_back import ssf_pkg::*; #(
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int TRIG_STAGES = TRIG_STAGES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  work_type head,
   input  logic     head_valid,
   output logic     pop,
   ssf_rsp_if.source rsp_ch
);

   localparam int K     = 60 - 2 * FRAC_BITS;
   localparam int NUM_W = 95 - K;
   localparam int LAT   = 108 + TRIG_STAGES;
   localparam logic [63:0] HALF_ULP = 64'd1 << (FRAC_BITS - 1);
   localparam logic signed [33:0] ONE34  = 34'sd1073741824;
   localparam logic signed [33:0] MONE34 = -34'sd1073741824;

   typedef struct packed {
      pass_type    pass;
      logic [31:0] sh;
      logic [31:0] cut;
      logic [63:0] rad;
      logic [33:0] rem;
      logic [31:0] root;
   } sqrt_type;

   typedef struct packed {
      pass_type    pass;
      logic [31:0] r;
      logic [31:0] span;
      logic        nz;
      logic [31:0] rem;
      logic [31:0] quo;
   } tdiv_type;

   typedef struct packed {
      pass_type           pass;
      logic [31:0]        r;
      logic [31:0]        span;
      logic               nz;
      logic               tzero;
      logic               flip;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [32:0] z;
   } cord_type;

   typedef struct packed {
      pass_type    pass;
      logic [31:0] r;
      logic [31:0] span;
      logic        nz;
      logic [30:0] sn;
      logic [31:0] cs;
   } clamp_type;

   typedef struct packed {
      pass_type    pass;
      logic        nz;
      logic [63:0] d;
      logic [63:0] eprod;
      logic [62:0] p;
   } mul_type;

   typedef struct packed {
      pass_type    pass;
      logic        nz;
      logic [63:0] d;
      logic [31:0] energy;
      logic [63:0] ppl;
      logic [62:0] pph;
   } pp_type;

   typedef struct packed {
      pass_type         pass;
      logic             nz;
      logic [63:0]      d;
      logic [31:0]      energy;
      logic [NUM_W-1:0] num;
   } num_type;

   typedef struct packed {
      pass_type    pass;
      logic        nz;
      logic [31:0] energy;
      logic [63:0] d;
      logic        ovf;
      logic [63:0] rem;
      logic [31:0] low;
      logic [31:0] quo;
   } fdiv_type;

   typedef struct packed {
      pass_type    pass;
      logic [31:0] energy;
      logic [31:0] fscale;
      logic [31:0] smag;
   } fs_type;

   typedef struct packed {
      pass_type         pass;
      logic [31:0]      energy;
      logic [31:0]      fscale;
      logic [2:0][63:0] prod;
   } fm_type;

   // one result bit of the square root
   function automatic sqrt_type sqrt_step(sqrt_type s);
      sqrt_type    o;
      logic [35:0] cur;
      logic [35:0] trial;
      o     = s;
      cur   = {s.rem, s.rad[63:62]};
      trial = {2'b00, s.root, 2'b01};
      o.rad = {s.rad[61:0], 2'b00};
      if (cur >= trial) begin
         o.rem  = 34'(cur - trial);
         o.root = {s.root[30:0], 1'b1};
      end else begin
         o.rem  = cur[33:0];
         o.root = {s.root[30:0], 1'b0};
      end
      return o;
   endfunction

   // one quotient bit of rshift * 2^32 / span
   function automatic tdiv_type tdiv_step(tdiv_type s);
      tdiv_type    o;
      logic [32:0] cur;
      o   = s;
      cur = {s.rem, 1'b0};
      if (cur >= {1'b0, s.span}) begin
         o.rem = 32'(cur - {1'b0, s.span});
         o.quo = {s.quo[30:0], 1'b1};
      end else begin
         o.rem = cur[31:0];
         o.quo = {s.quo[30:0], 1'b0};
      end
      return o;
   endfunction

   // one CORDIC rotation
   function automatic cord_type cord_step(cord_type s, logic [4:0] k);
      cord_type           o;
      logic signed [33:0] x, y, xs, ys;
      logic signed [32:0] z, at;
      o  = s;
      x  = s.x;
      y  = s.y;
      z  = s.z;
      xs = x >>> k;
      ys = y >>> k;
      at = $signed({1'b0, ATAN_TAB[k]});
      if (!z[32]) begin
         x = x - ys;
         y = y + xs;
         z = z - at;
      end else begin
         x = x + ys;
         y = y - xs;
         z = z + at;
      end
      o.x = x;
      o.y = y;
      o.z = z;
      return o;
   endfunction

   // one quotient bit of the force scale division
   function automatic fdiv_type fdiv_step(fdiv_type s);
      fdiv_type    o;
      logic [64:0] cur;
      logic [64:0] dd;
      o     = s;
      cur   = {s.rem, s.low[31]};
      dd    = {1'b0, s.d};
      o.low = {s.low[30:0], 1'b0};
      if (cur >= dd) begin
         o.rem = 64'(cur - dd);
         o.quo = {s.quo[30:0], 1'b1};
      end else begin
         o.rem = cur[63:0];
         o.quo = {s.quo[30:0], 1'b0};
      end
      return o;
   endfunction

   sqrt_type     sq_ff [0:32];
   tdiv_type     td_ff [0:32];
   cord_type     ar_ff;
   cord_type     cd_ff [0:TRIG_STAGES];
   clamp_type    sc_ff, sc_in;
   mul_type      mu_ff, mu_in;
   pp_type       pp_ff, pp_in;
   num_type      nm_ff, nm_in;
   fdiv_type     fd_ff [0:32];
   fs_type       fs_ff, fs_in;
   fm_type       fm_ff, fm_in;
   rsp_word_type out_ff, out_in;
   logic [LAT-1:0] vld_ff;
   logic           en;

   assign en  = !vld_ff[LAT-1] || rsp_ch.ready;
   assign pop = en && head_valid;

   assign rsp_ch.valid       = vld_ff[LAT-1];
   assign rsp_ch.fx          = out_ff.fx;
   assign rsp_ch.fy          = out_ff.fy;
   assign rsp_ch.fz          = out_ff.fz;
   assign rsp_ch.force_scale = out_ff.force_scale;
   assign rsp_ch.energy      = out_ff.energy;
   assign rsp_ch.in_range    = out_ff.in_range;

   // load from the queue head
   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0] <= '{pass: head.pass, sh: head.sh, cut: head.cut, rad: head.rsq,
                       rem: '0, root: '0};
      end
   end

   // square root, one bit per stage
   for (genvar i = 1; i <= 32; i++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[i] <= sqrt_step(sq_ff[i-1]);
         end
      end
   end

   // shifted distance and span
   always_ff @(posedge clock) begin
      if (en) begin
         td_ff[0].pass <= sq_ff[32].pass;
         td_ff[0].r    <= sq_ff[32].root;
         td_ff[0].span <= sq_ff[32].cut - sq_ff[32].sh;
         td_ff[0].nz   <= sq_ff[32].root > sq_ff[32].sh;
         td_ff[0].rem  <= (sq_ff[32].root > sq_ff[32].sh) ?
                          (sq_ff[32].root - sq_ff[32].sh) : 32'd0;
         td_ff[0].quo  <= '0;
      end
   end

   // phase t = rshift / span in Q0.32, one bit per stage
   for (genvar i = 1; i <= 32; i++) begin : g_tdiv
      always_ff @(posedge clock) begin
         if (en) begin
            td_ff[i] <= tdiv_step(td_ff[i-1]);
         end
      end
   end

   // angle = pi * t
   always_ff @(posedge clock) begin
      logic [31:0] tq;
      logic [63:0] ang;
      if (en) begin
         tq = td_ff[32].nz ? td_ff[32].quo : 32'd0;
         ang = 64'(tq) * 64'(PI_Q30);
         ar_ff.pass  <= td_ff[32].pass;
         ar_ff.r     <= td_ff[32].r;
         ar_ff.span  <= td_ff[32].span;
         ar_ff.nz    <= td_ff[32].nz;
         ar_ff.tzero <= tq == 32'd0;
         ar_ff.flip  <= 1'b0;
         ar_ff.x     <= '0;
         ar_ff.y     <= '0;
         ar_ff.z     <= $signed({1'b0, ang[63:32]});
      end
   end

   // fold into the first quadrant and seed the rotation
   always_ff @(posedge clock) begin
      cord_type    c;
      logic [31:0] a;
      logic        fl;
      if (en) begin
         a      = ar_ff.z[31:0];
         fl     = a > HALF_PI_Q30;
         c      = ar_ff;
         c.flip = fl;
         c.x    = $signed({2'b00, GAIN_Q30});
         c.y    = '0;
         c.z    = $signed({1'b0, fl ? (PI_Q30 - a) : a});
         cd_ff[0] <= c;
      end
   end

   for (genvar i = 1; i <= TRIG_STAGES; i++) begin : g_cord
      always_ff @(posedge clock) begin
         if (en) begin
            cd_ff[i] <= cord_step(cd_ff[i-1], 5'(i - 1));
         end
      end
   end

   // unfold and clamp sin / cos
   always_comb begin
      logic signed [33:0] xv, yv;
      xv          = cd_ff[TRIG_STAGES].x;
      yv          = cd_ff[TRIG_STAGES].y;
      xv          = cd_ff[TRIG_STAGES].flip ? -xv : xv;
      sc_in.pass  = cd_ff[TRIG_STAGES].pass;
      sc_in.r     = cd_ff[TRIG_STAGES].r;
      sc_in.span  = cd_ff[TRIG_STAGES].span;
      sc_in.nz    = cd_ff[TRIG_STAGES].nz;
      if (yv < 34'sd0) begin
         sc_in.sn = '0;
      end else if (yv > ONE34) begin
         sc_in.sn = ONE_Q30[30:0];
      end else begin
         sc_in.sn = yv[30:0];
      end
      if (xv < MONE34) begin
         sc_in.cs = 32'd0 - ONE_Q30;
      end else if (xv > ONE34) begin
         sc_in.cs = ONE_Q30;
      end else begin
         sc_in.cs = xv[31:0];
      end
      if (cd_ff[TRIG_STAGES].tzero) begin
         sc_in.sn = '0;
         sc_in.cs = ONE_Q30;
      end
   end

   // energy product, sin product, divisor span * r
   always_comb begin
      logic [31:0] ofs;
      ofs         = sc_ff.cs + ONE_Q30;
      mu_in.pass  = sc_ff.pass;
      mu_in.nz    = sc_ff.nz;
      mu_in.d     = 64'(sc_ff.span) * 64'(sc_ff.r);
      mu_in.eprod = 64'(sc_ff.pass.m) * 64'(ofs);
      mu_in.p     = 63'(sc_ff.pass.m) * 63'(sc_ff.sn);
   end

   // energy rounding, partial products with pi
   always_comb begin
      logic [63:0] e;
      e            = (mu_ff.eprod + 64'd536870912) >> 30;
      pp_in.pass   = mu_ff.pass;
      pp_in.nz     = mu_ff.nz;
      pp_in.d      = mu_ff.d;
      pp_in.energy = sat_field(mu_ff.pass.aneg, e);
      pp_in.ppl    = 64'(mu_ff.p[31:0]) * 64'(PI_Q30);
      pp_in.pph    = 63'(mu_ff.p[62:32]) * 63'(PI_Q30);
   end

   // dividend of the force scale
   always_comb begin
      logic [94:0] sum;
      sum          = {pp_ff.pph, 32'd0} + 95'(pp_ff.ppl);
      nm_in.pass   = pp_ff.pass;
      nm_in.nz     = pp_ff.nz;
      nm_in.d      = pp_ff.d;
      nm_in.energy = pp_ff.energy;
      nm_in.num    = sum[94:K];
   end

   // overflow check on the upper dividend, then long division
   always_ff @(posedge clock) begin
      if (en) begin
         sc_ff <= sc_in;
         mu_ff <= mu_in;
         pp_ff <= pp_in;
         nm_ff <= nm_in;
         fd_ff[0].pass   <= nm_ff.pass;
         fd_ff[0].nz     <= nm_ff.nz;
         fd_ff[0].energy <= nm_ff.energy;
         fd_ff[0].d      <= nm_ff.d;
         fd_ff[0].ovf    <= 64'(nm_ff.num[NUM_W-1:32]) >= nm_ff.d;
         fd_ff[0].rem    <= 64'(nm_ff.num[NUM_W-1:32]);
         fd_ff[0].low    <= nm_ff.num[31:0];
         fd_ff[0].quo    <= '0;
      end
   end

   for (genvar i = 1; i <= 32; i++) begin : g_fdiv
      always_ff @(posedge clock) begin
         if (en) begin
            fd_ff[i] <= fdiv_step(fd_ff[i-1]);
         end
      end
   end

   // saturated force scale
   always_comb begin
      logic [63:0] raw;
      raw          = fd_ff[32].ovf ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(fd_ff[32].quo);
      fs_in.pass   = fd_ff[32].pass;
      fs_in.energy = fd_ff[32].energy;
      fs_in.smag   = fd_ff[32].nz ? sat_mag(fd_ff[32].pass.aneg, raw) : 32'd0;
      fs_in.fscale = sat_field(fd_ff[32].pass.aneg, 64'(fs_in.smag));
   end

   // force products
   always_comb begin
      fm_in.pass   = fs_ff.pass;
      fm_in.energy = fs_ff.energy;
      fm_in.fscale = fs_ff.fscale;
      for (int j = 0; j < 3; j++) begin
         fm_in.prod[j] = 64'(fs_ff.pass.dmag[j]) * 64'(fs_ff.smag);
      end
   end

   // round forces, zero everything outside the cutoff
   always_comb begin
      logic [2:0][31:0] f;
      for (int j = 0; j < 3; j++) begin
         f[j] = sat_field(fm_ff.pass.dneg[j] ^ fm_ff.pass.aneg,
                          (fm_ff.prod[j] + HALF_ULP) >> FRAC_BITS);
      end
      out_in = '0;
      if (fm_ff.pass.in_range) begin
         out_in.fx          = f[0];
         out_in.fy          = f[1];
         out_in.fz          = f[2];
         out_in.force_scale = fm_ff.fscale;
         out_in.energy      = fm_ff.energy;
         out_in.in_range    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fs_ff  <= fs_in;
         fm_ff  <= fm_in;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], head_valid};
      end
   end

endmodule

FILE: sv/shifted_soft_pair_force.sv
// Shifted soft cosine pair force kernel: one pair word in, one force/energy word out,
// one word per clock sustained while neither port stalls. A three-stage front end forms
// r^2, the cutoff test and the weighted strength and fills a four-word queue; the back
// end is a fully pipelined chain (32-stage square root, 32-stage phase divider,
// TRIG_STAGES CORDIC stages, 32-stage force-scale divider and a dozen arithmetic
// stages) of 108 + TRIG_STAGES registers that advances whenever its output register
// is free or taken. An input word passes the front end, the queue and the back-end
// chain in order; a stalled result port halts the back end, and the queue fills with
// the front end's words before the input port deasserts ready.
`timescale 1ns / 1ps

module shifted_soft_pair_force import ssf_pkg::*; #(
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int TRIG_STAGES = TRIG_STAGES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ssf_req_if.sink   req_ch,
   ssf_rsp_if.source rsp_ch
);

   work_type push_data, head;
   logic     push_valid, push_ready, head_valid, pop;

   ssf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   ssf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop)
   );

   ssf_back #(
      .FRAC_BITS   (FRAC_BITS),
      .TRIG_STAGES (TRIG_STAGES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

FILE: sim/tb_shifted_soft_pair_force.sv
// Testbench for the shifted soft pair force kernel: random and directed pairs, scoreboard check.
`timescale 1ns / 1ps

module tb_shifted_soft_pair_force;
   import ssf_pkg::*;

   localparam int FB = FRAC_BITS_DEF;
   localparam int TS = TRIG_STAGES_DEF;
   localparam int N_RANDOM = 550;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [31:0] dx;
      logic [31:0] dy;
      logic [31:0] dz;
      logic [15:0] weight;
      logic [31:0] strength;
      logic [31:0] shift_dist;
      logic [31:0] cutoff;
   } pair_type;

   logic clock;
   logic reset;
   ssf_req_if req_ch ();
   ssf_rsp_if rsp_ch ();

   shifted_soft_pair_force u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   pair_type     pending_pairs [$];
   rsp_word_type expected_words [$];
   int           error_count;
   int           cycle_count;
   bit           quiet_phase;
   bit           req_taken;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // arithmetic shift right on a 64 bit signed value
   function automatic longint asr64(longint v, int s);
      return v >>> s;
   endfunction

   // floor square root of a 64 bit value
   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // CORDIC sin/cos of pi*t, t in Q0.32
   function automatic void sincos_of_phase(input logic [63:0] t, output longint sn,
                                           output longint cs);
      logic [63:0] arg;
      bit          flip;
      longint      x, y, z, xs, ys, ang;
      arg = (t * 64'(PI_Q30)) >> 32;
      flip = 0;
      x = longint'(GAIN_Q30);
      y = 0;
      if (t == 0) begin
         sn = 0;
         cs = longint'(ONE_Q30);
         return;
      end
      if (arg > 64'(HALF_PI_Q30)) begin
         arg = 64'(PI_Q30) - arg;
         flip = 1;
      end
      z = longint'(arg);
      for (int i = 0; i < TS; i++) begin
         xs = asr64(x, i & 31);
         ys = asr64(y, i & 31);
         ang = longint'(ATAN_TAB[i & 31]);
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - ang;
         end else begin
            x = x + ys; y = y - xs; z = z + ang;
         end
      end
      if (flip) x = -x;
      if (y < 0) y = 0;
      if (y > longint'(ONE_Q30)) y = longint'(ONE_Q30);
      if (x < -longint'(ONE_Q30)) x = -longint'(ONE_Q30);
      if (x > longint'(ONE_Q30)) x = longint'(ONE_Q30);
      sn = y;
      cs = x;
   endfunction

   // expected force/energy word of one pair
   function automatic rsp_word_type pair_force(pair_type p);
      rsp_word_type w;
      logic [2:0][31:0] dm;
      logic [2:0]       dn;
      logic [63:0]  rsq, r, rshift, m, t, emag, smag, fm, span, amag;
      logic [127:0] num;
      longint       sn, cs;
      bit           aneg;
      logic [31:0]  fo [3];
      w = '0;
      dn[0] = p.dx[31]; dn[1] = p.dy[31]; dn[2] = p.dz[31];
      dm[0] = abs32(p.dx); dm[1] = abs32(p.dy); dm[2] = abs32(p.dz);
      rsq = 0;
      for (int j = 0; j < 3; j++) rsq = rsq + 64'(dm[j]) * 64'(dm[j]);
      aneg = p.strength[31];
      amag = 64'(abs32(p.strength));
      if (!(rsq < 64'(p.cutoff) * 64'(p.cutoff))) return w;
      w.in_range = 1'b1;
      r = root_floor(rsq);
      rshift = (r > 64'(p.shift_dist)) ? r - 64'(p.shift_dist) : 0;
      m = (64'(p.weight) * amag + 64'd16384) >> 15;
      span = 64'(p.cutoff) - 64'(p.shift_dist);
      t = 0;
      if (rshift > 0 && p.cutoff > p.shift_dist) t = (rshift << 32) / span;
      sincos_of_phase(t, sn, cs);
      emag = (m * 64'(longint'(ONE_Q30) + cs) + (64'd1 << 29)) >> 30;
      w.energy = sat_field(aneg, emag);
      smag = 0;
      if (rshift > 0 && p.cutoff > p.shift_dist && r > 0) begin
         num = (128'(m * 64'(sn)) * 128'(PI_Q30)) >> (60 - 2 * FB);
         num = num / 128'(span * r);
         smag = (num > 128'hFFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : num[63:0];
         smag = 64'(sat_mag(aneg, smag));
      end
      w.force_scale = sat_field(aneg, smag);
      for (int j = 0; j < 3; j++) begin
         fm = (64'(dm[j]) * smag + (64'd1 << (FB - 1))) >> FB;
         fo[j] = sat_field(dn[j] != aneg, fm);
      end
      w.fx = fo[0]; w.fy = fo[1]; w.fz = fo[2];
      return w;
   endfunction

   function automatic logic [31:0] rand_coord(int range_sel);
      logic [31:0] v;
      case (range_sel)
         0: v = $urandom;
         1: v = $urandom_range(0, 32'h0008_0000);
         default: v = $urandom_range(0, 32'h0000_4000);
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   function automatic pair_type rand_pair();
      pair_type p;
      int       sel;
      sel = $urandom_range(0, 9);
      p.dx = rand_coord(sel < 2 ? 0 : (sel < 7 ? 1 : 2));
      p.dy = rand_coord(sel < 2 ? 0 : (sel < 7 ? 1 : 2));
      p.dz = rand_coord(sel < 2 ? 0 : (sel < 7 ? 1 : 2));
      p.weight = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
      p.strength = $urandom;
      if (sel < 2) begin
         p.shift_dist = $urandom;
         p.cutoff = $urandom;
      end else begin
         // mostly well-formed pairs that land inside the cutoff
         p.shift_dist = $urandom_range(0, 32'h0008_0000);
         p.cutoff = p.shift_dist + $urandom_range(1, 32'h0010_0000);
      end
      return p;
   endfunction

   task automatic add_pair(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                           logic [15:0] wt, logic [31:0] a, logic [31:0] sh, logic [31:0] cut);
      pair_type p;
      p = '{dx, dy, dz, wt, a, sh, cut};
      pending_pairs.push_back(p);
   endtask

   // driver: present words at the falling edge, hold until taken
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_taken) begin
         // hold the word
      end else begin
         if (pending_pairs.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 30)) begin
            req_ch.valid      <= 1'b1;
            req_ch.dx         <= pending_pairs[0].dx;
            req_ch.dy         <= pending_pairs[0].dy;
            req_ch.dz         <= pending_pairs[0].dz;
            req_ch.weight     <= pending_pairs[0].weight;
            req_ch.strength   <= pending_pairs[0].strength;
            req_ch.shift_dist <= pending_pairs[0].shift_dist;
            req_ch.cutoff     <= pending_pairs[0].cutoff;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result-side stall pattern
   always @(negedge clock) begin
      rsp_ch.ready <= quiet_phase || ($urandom_range(0, 99) >= 30);
   end

   // monitor: predict on accept, compare on result
   always @(posedge clock) begin
      rsp_word_type exp_w;
      req_taken <= req_ch.valid && req_ch.ready && !reset;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (req_ch.valid && req_ch.ready) begin
            expected_words.push_back(pair_force(pending_pairs[0]));
            pending_pairs.pop_front();
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected result word %h", $time,
                        {rsp_ch.fx, rsp_ch.fy, rsp_ch.fz, rsp_ch.force_scale,
                         rsp_ch.energy, rsp_ch.in_range});
               error_count <= error_count + 1;
            end else begin
               exp_w = expected_words.pop_front();
               if (rsp_ch.fx !== exp_w.fx || rsp_ch.fy !== exp_w.fy ||
                   rsp_ch.fz !== exp_w.fz || rsp_ch.force_scale !== exp_w.force_scale ||
                   rsp_ch.energy !== exp_w.energy || rsp_ch.in_range !== exp_w.in_range) begin
                  $display("%0t: mismatch expected fx %h fy %h fz %h fs %h e %h ir %b", $time,
                           exp_w.fx, exp_w.fy, exp_w.fz, exp_w.force_scale,
                           exp_w.energy, exp_w.in_range);
                  $display("%0t:          actual   fx %h fy %h fz %h fs %h e %h ir %b", $time,
                           rsp_ch.fx, rsp_ch.fy, rsp_ch.fz, rsp_ch.force_scale,
                           rsp_ch.energy, rsp_ch.in_range);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

   // timeout watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_shifted_soft_pair_force failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.dx = '0; req_ch.dy = '0; req_ch.dz = '0;
      req_ch.weight = '0; req_ch.strength = '0;
      req_ch.shift_dist = '0; req_ch.cutoff = '0;
      rsp_ch.ready = 1'b0;
      error_count = 0;
      cycle_count = 0;
      quiet_phase = 0;
      req_taken = 0;

      // directed pairs
      add_pair(32'h0001_0000, 0, 0, 16'd32768, 32'h0001_0000, 0, 32'h0002_0000);
      add_pair(0, 0, 0, 16'd32768, 32'h0001_0000, 0, 32'h0001_0000);          // r = 0
      add_pair(32'h0003_0000, 0, 0, 16'd32768, 32'h0001_0000, 0, 32'h0002_0000); // outside
      add_pair(32'h0002_0000, 0, 0, 16'd32768, 32'h0001_0000, 0, 32'h0002_0000); // on cutoff
      add_pair(32'h0000_8000, 0, 0, 16'd32768, 32'hFFFF_0000, 32'h0001_0000,
               32'h0002_0000);                                                   // inside shift
      add_pair(32'h0001_0000, 32'h0001_0000, 0, 16'd32768, 32'h0001_0000,
               32'h0004_0000, 32'h0003_0000);                                    // shift above cutoff
      add_pair(32'h0001_8000, 32'hFFFF_0000, 32'h0000_4000, 16'hFFFF, 32'h7FFF_FFFF,
               32'h0000_8000, 32'h0002_0000);                                    // weight above one
      add_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd32768, 32'h8000_0000,
               0, 32'hFFFF_FFFF);
      add_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_pair(32'h0000_0010, 32'hFFFF_FFF0, 32'h0000_0001, 16'd32768, 32'h7FFF_FFFF,
               0, 32'h0000_0100);                                                // overflow
      add_pair(32'hFFFF_FFFF, 0, 0, 0, 32'h0001_0000, 0, 32'h0001_0000);       // zero weight
      add_pair(32'h0001_FFFF, 0, 0, 16'd16384, 32'hFFFF_FFFF, 32'h0001_0000,
               32'h0002_0000);                                                   // near pi
      add_pair(0, 32'h0001_0000, 0, 16'd32768, 32'h0001_0000, 32'h0001_0000,
               32'h0001_0000);
      add_pair(0, 0, 32'h0000_0001, 16'd1, 32'h0000_0001, 0, 32'h0000_0002);
      for (int i = 0; i < N_RANDOM; i++) pending_pairs.push_back(rand_pair());

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // a long stretch without idling in the middle of the run
      wait (pending_pairs.size() < 300);
      quiet_phase = 1;
      wait (pending_pairs.size() < 200);
      quiet_phase = 0;

      wait (pending_pairs.size() == 0 && !req_ch.valid);
      wait (expected_words.size() == 0);
      repeat (2 * (113 + TS)) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("tb_shifted_soft_pair_force passed");
      end else begin
         $display("tb_shifted_soft_pair_force failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/ssf_pkg.sv
sv/ssf_req_if.sv
sv/ssf_rsp_if.sv
sv/ssf_front.sv
sv/ssf_queue.sv
sv/ssf_back.sv
sv/shifted_soft_pair_force.sv
sim/tb_shifted_soft_pair_force.sv
